// ===== src/plst_pkg.sv =====
// ----------------------------------------------------------------------------
// plst_pkg
// shared types and codes of the positional list engine
// ----------------------------------------------------------------------------
package plst_pkg;

  localparam int unsigned ValW   = 31;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned LenOutW = 7;
  localparam int unsigned PosW   = 7;

  typedef enum logic [2:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_INS_POS  = 3'd2,
    CMD_REM_HEAD = 3'd3,
    CMD_REM_TAIL = 3'd4,
    CMD_REM_POS  = 3'd5,
    CMD_DUMP     = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_WALK,
    S_INS_DRAIN,
    S_INS_PUT,
    S_REM_WALK,
    S_REM_DRAIN,
    S_DUMP_RD,
    S_DUMP_OUT,
    S_RESP
  } state_e;

  // one result transaction handed to the output stage
  typedef struct packed {
    logic [ValW-1:0]    value;
    logic [IdxW-1:0]    index;
    status_e            status;
    logic [LenOutW-1:0] length;
    logic               last;
  } result_t;

endpackage

// ===== src/plst_ram.sv =====
// ----------------------------------------------------------------------------
// plst_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module plst_ram #(
  parameter int unsigned Width = 31,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/plst_out_stage.sv =====
// ----------------------------------------------------------------------------
// plst_out_stage
// output register of the result channel
// ----------------------------------------------------------------------------
module plst_out_stage
  import plst_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  result_t             res_i,
  output logic                slot_free_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ValW-1:0]     value_out_o,
  output logic [IdxW-1:0]     entry_index_o,
  output logic [1:0]          status_o,
  output logic [LenOutW-1:0]  length_o,
  output logic                last_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign slot_free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign value_out_o   = res_q.value;
  assign entry_index_o = res_q.index;
  assign status_o      = res_q.status;
  assign length_o      = res_q.length;
  assign last_o        = res_q.last;

endmodule

// ===== src/plst_ctrl.sv =====
// ----------------------------------------------------------------------------
// plst_ctrl
// command decode and memory walk sequencer of the positional list engine
// ----------------------------------------------------------------------------
module plst_ctrl
  import plst_pkg::*;
#(
  parameter int unsigned Capacity = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  cmd_i,
  input  logic [PosW-1:0]             position_i,
  input  logic [ValW-1:0]             value_i,
  output logic                        re_o,
  output logic [$clog2(Capacity)-1:0] raddr_o,
  input  logic [ValW-1:0]             rdata_i,
  output logic                        we_o,
  output logic [$clog2(Capacity)-1:0] waddr_o,
  output logic [ValW-1:0]             wdata_o,
  input  logic                        slot_free_i,
  output logic                        load_o,
  output result_t                     res_o
);

  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned LW = $clog2(Capacity + 1);
  localparam int unsigned CW = (LW > PosW) ? LW : PosW;
  localparam int unsigned XW = (CW > LenOutW) ? CW : LenOutW;
  localparam int unsigned IW = (AW > IdxW) ? AW : IdxW;

  state_e          state_q, state_d;
  logic [LW-1:0]   len_q, len_d;
  logic            pend_q, pend_d;
  logic [AW-1:0]   src_q, src_d;
  logic [AW-1:0]   prev_q;
  logic [AW-1:0]   pos_q, end_q;
  logic [ValW-1:0] val_q, got_q, got_d;
  status_e         st_q;

  logic            in_fire;
  logic [CW-1:0]   len_ext, pos_ext;
  logic            is_ins, is_rem, is_dump, len_full, len_zero;
  status_e         dec_st;
  logic [XW-1:0]   len_out;
  logic [IW-1:0]   idx_ext;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && (state_q == S_IDLE);
  assign len_ext    = CW'(len_q);
  assign len_full   = (len_q == LW'(Capacity));
  assign len_zero   = (len_q == '0);
  assign len_out    = XW'(len_q);
  assign idx_ext    = IW'(src_q);

  // command decode
  always_comb begin
    pos_ext = '0;
    is_ins  = 1'b0;
    is_rem  = 1'b0;
    is_dump = 1'b0;
    dec_st  = ST_OK;
    unique case (cmd_i)
      CMD_INS_HEAD: is_ins = 1'b1;
      CMD_INS_TAIL: begin
        is_ins  = 1'b1;
        pos_ext = len_ext;
      end
      CMD_INS_POS: begin
        is_ins  = 1'b1;
        pos_ext = CW'(position_i);
      end
      CMD_REM_HEAD: begin
        if (len_zero) dec_st = ST_EMPTY;
        else is_rem = 1'b1;
      end
      CMD_REM_TAIL: begin
        pos_ext = len_ext - 1'b1;
        if (len_zero) dec_st = ST_EMPTY;
        else is_rem = 1'b1;
      end
      CMD_REM_POS: begin
        is_rem  = 1'b1;
        pos_ext = CW'(position_i);
      end
      CMD_DUMP: begin
        if (len_zero) dec_st = ST_EMPTY;
        else is_dump = 1'b1;
      end
      default: dec_st = ST_BADPOS;
    endcase
    // bad position is checked before the full list
    if (is_ins) begin
      if (pos_ext > len_ext) dec_st = ST_BADPOS;
      else if (len_full)     dec_st = ST_FULL;
    end
    if (is_rem && (pos_ext >= len_ext)) begin
      dec_st = ST_BADPOS;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          priority if (dec_st != ST_OK) state_d = S_RESP;
          else if (is_ins)              state_d = (pos_ext == len_ext) ? S_INS_PUT : S_INS_WALK;
          else if (is_rem)              state_d = S_REM_WALK;
          else if (is_dump)             state_d = S_DUMP_RD;
        end
      end
      S_INS_WALK:  if (src_q == pos_q) state_d = S_INS_DRAIN;
      S_INS_DRAIN: state_d = S_INS_PUT;
      S_INS_PUT:   state_d = S_RESP;
      S_REM_WALK:  if (src_q == end_q) state_d = S_REM_DRAIN;
      S_REM_DRAIN: state_d = S_RESP;
      S_DUMP_RD:   state_d = S_DUMP_OUT;
      S_DUMP_OUT:  if (slot_free_i && (src_q == end_q)) state_d = S_IDLE;
      S_RESP:      if (slot_free_i) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // memory and result outputs
  always_comb begin
    re_o         = 1'b0;
    raddr_o      = src_q;
    we_o         = 1'b0;
    waddr_o      = AW'(prev_q + 1'b1);
    wdata_o      = rdata_i;
    load_o       = 1'b0;
    res_o.value  = got_q;
    res_o.index  = '0;
    res_o.status = st_q;
    res_o.length = len_out[LenOutW-1:0];
    res_o.last   = 1'b1;
    unique case (state_q)
      S_INS_WALK: begin
        re_o = 1'b1;
        we_o = pend_q;
      end
      S_INS_DRAIN: we_o = 1'b1;
      S_INS_PUT: begin
        we_o    = 1'b1;
        waddr_o = pos_q;
        wdata_o = val_q;
      end
      S_REM_WALK, S_REM_DRAIN: begin
        re_o    = (state_q == S_REM_WALK);
        we_o    = pend_q && (prev_q != pos_q);
        waddr_o = AW'(prev_q - 1'b1);
      end
      S_DUMP_RD: re_o = 1'b1;
      S_DUMP_OUT: begin
        load_o       = slot_free_i;
        res_o.value  = rdata_i;
        res_o.index  = idx_ext[IdxW-1:0];
        res_o.status = ST_OK;
        res_o.last   = (src_q == end_q);
        re_o         = slot_free_i && (src_q != end_q);
        raddr_o      = AW'(src_q + 1'b1);
      end
      S_RESP: load_o = slot_free_i;
      default: ;
    endcase
  end

  // walk pointer, length and removed value
  always_comb begin
    src_d  = src_q;
    len_d  = len_q;
    got_d  = got_q;
    pend_d = (state_q == S_INS_WALK) || (state_q == S_REM_WALK);
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          got_d = '0;
          if (dec_st == ST_OK) begin
            priority if (is_ins) begin
              len_d = len_q + 1'b1;
              src_d = AW'(len_q - 1'b1);
            end else if (is_rem) begin
              len_d = len_q - 1'b1;
              src_d = AW'(pos_ext);
            end else begin
              src_d = '0;
            end
          end
        end
      end
      S_INS_WALK: src_d = AW'(src_q - 1'b1);
      S_REM_WALK, S_REM_DRAIN: begin
        if (state_q == S_REM_WALK) src_d = AW'(src_q + 1'b1);
        if (pend_q && (prev_q == pos_q)) got_d = rdata_i;
      end
      S_DUMP_OUT: if (re_o) src_d = AW'(src_q + 1'b1);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q  <= src_d;
    got_q  <= got_d;
    prev_q <= src_q;
    if (in_fire) begin
      pos_q <= AW'(pos_ext);
      end_q <= AW'(len_q - 1'b1);
      val_q <= value_i;
      st_q  <= dec_st;
    end
  end

  // list never grows beyond its capacity
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(Capacity))
    else $error("list length beyond capacity");

  // a walk never reads and writes the same entry in one cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (re_o && we_o) |-> (raddr_o != waddr_o))
    else $error("read and write of the same entry");

  // length only moves on an accepted command
  a_len_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(len_q) |-> $past(in_fire))
    else $error("length changed without a command");

  // results are only handed over when the output register can take them
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_o |-> slot_free_i)
    else $error("result loaded into a busy output register");

endmodule

// ===== src/positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine
// ordered list of record identifiers with positional insert, remove and dump
// ----------------------------------------------------------------------------
// The list sits packed in list order in one ram of CAPACITY entries with a
// single read and a single write port, and commands are processed one at a
// time. An insert at position p into a list of length L moves the L-p entries
// behind p up by one place, one entry per cycle, and then writes the new
// identifier. A remove at p reads the entry and moves the L-p-1 entries
// behind it down by one place, also one entry per cycle. A dump reads one
// entry per cycle while the result side does not stall and delivers one
// result transaction per entry. The walk through the ram port sets how long a
// command takes. The result sits in an output register, so a new command
// transaction is taken while the previous result still waits on the result
// side. After reset the list is empty; no clearing pass is needed since only
// entries below the length are ever read.
// ----------------------------------------------------------------------------
module positional_list_engine
  import plst_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         cmd_i,
  input  logic [PosW-1:0]    position_i,
  input  logic [ValW-1:0]    value_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ValW-1:0]    value_out_o,
  output logic [IdxW-1:0]    entry_index_o,
  output logic [1:0]         status_o,
  output logic [LenOutW-1:0] length_o,
  output logic               last_o
);

  localparam int unsigned AW = $clog2(CAPACITY);

  // ram access of the sequencer
  logic            re, we;
  logic [AW-1:0]   raddr, waddr;
  logic [ValW-1:0] rdata, wdata;

  // handover to the output register
  logic            load, slot_free;
  result_t         res;

  // list contents, one identifier per entry
  plst_ram #(
    .Width (ValW),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // decode, length bookkeeping and the shift and dump walks
  plst_ctrl #(
    .Capacity (CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .slot_free_i (slot_free),
    .load_o      (load),
    .res_o       (res)
  );

  // result register, parts the walk from the result side
  plst_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .res_i         (res),
    .slot_free_o   (slot_free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .value_out_o   (value_out_o),
    .entry_index_o (entry_index_o),
    .status_o      (status_o),
    .length_o      (length_o),
    .last_o        (last_o)
  );

endmodule

// ===== verif/list_checker.sv =====
// ----------------------------------------------------------------------------
// list_checker
// watches both channels of the positional list engine, keeps a shadow list,
// and compares every result transaction against the predicted one
// ----------------------------------------------------------------------------
module list_checker
  import plst_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [2:0]         cmd_i,
  input  logic [PosW-1:0]    position_i,
  input  logic [ValW-1:0]    value_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [ValW-1:0]    value_out_i,
  input  logic [IdxW-1:0]    entry_index_i,
  input  logic [1:0]         status_i,
  input  logic [LenOutW-1:0] length_i,
  input  logic               last_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 list_len_o
);

  logic [ValW-1:0] id_store [CAPACITY];
  int unsigned     id_count;
  result_t         awaited [$];
  result_t         want;
  int              mismatches;

  function automatic status_e insert_id(int unsigned at, logic [ValW-1:0] id);
    if (at > id_count) return ST_BADPOS;
    if (id_count >= CAPACITY) return ST_FULL;
    for (int unsigned i = id_count; i > at; i--) id_store[i] = id_store[i-1];
    id_store[at] = id;
    id_count++;
    return ST_OK;
  endfunction

  function automatic status_e remove_id(int unsigned at, output logic [ValW-1:0] id);
    id = '0;
    if (at >= id_count) return ST_BADPOS;
    id = id_store[at];
    for (int unsigned i = at; i + 1 < id_count; i++) id_store[i] = id_store[i+1];
    id_count--;
    return ST_OK;
  endfunction

  // works out the result transactions of one command and queues them
  task automatic predict_command(logic [2:0] op, logic [PosW-1:0] pos,
                                 logic [ValW-1:0] id);
    logic [ValW-1:0] taken;
    status_e         st;
    taken = '0;
    st    = ST_BADPOS;
    if (op == CMD_DUMP) begin
      if (id_count == 0) begin
        awaited.push_back('{value: '0, index: '0, status: ST_EMPTY,
                            length: '0, last: 1'b1});
      end else begin
        for (int unsigned i = 0; i < id_count; i++)
          awaited.push_back('{value: id_store[i], index: IdxW'(i), status: ST_OK,
                              length: LenOutW'(id_count),
                              last: (i + 1 == id_count)});
      end
    end else begin
      case (op)
        CMD_INS_HEAD: st = insert_id(0, id);
        CMD_INS_TAIL: st = insert_id(id_count, id);
        CMD_INS_POS:  st = insert_id(int'(pos), id);
        CMD_REM_HEAD: begin
          if (id_count == 0) st = ST_EMPTY;
          else st = remove_id(0, taken);
        end
        CMD_REM_TAIL: begin
          if (id_count == 0) st = ST_EMPTY;
          else st = remove_id(id_count - 1, taken);
        end
        CMD_REM_POS:  st = remove_id(int'(pos), taken);
        default:      st = ST_BADPOS;
      endcase
      awaited.push_back('{value: taken, index: '0, status: st,
                          length: LenOutW'(id_count), last: 1'b1});
    end
  endtask

  function automatic void compare_field(string field, logic [ValW-1:0] want_v,
                                        logic [ValW-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", field, want_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_count = 0;
      awaited.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o <= 0;
      list_len_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited.size() == 0) begin
          $error("result transaction with nothing awaited: value_out %0h status %0d",
                 value_out_i, status_i);
          mismatches++;
        end else begin
          want = awaited.pop_front();
          compare_field("value_out", want.value, value_out_i);
          compare_field("entry_index", want.index, entry_index_i);
          compare_field("status", want.status, status_i);
          compare_field("length", want.length, length_i);
          compare_field("last", want.last, last_i);
        end
      end
      if (in_valid_i && !in_stall_i) predict_command(cmd_i, position_i, value_i);
      fail_count_o <= mismatches;
      pending_o <= awaited.size();
      list_len_o <= id_count;
    end
  end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives command transactions into the positional list engine with random
// gaps and result stalls; a checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module testbench;
  import plst_pkg::*;

  localparam int unsigned CAPACITY   = 64;
  localparam int          CycleLimit = 20_000_000;
  localparam int          ItemTarget = 470;
  localparam logic [2:0]  CMD_UNUSED = 3'd7;
  localparam logic [ValW-1:0] IdOnes = '1;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  // command side
  logic               cmd_valid = 1'b0;
  logic               cmd_stall;
  logic [2:0]         cmd_op = '0;
  logic [PosW-1:0]    cmd_pos = '0;
  logic [ValW-1:0]    cmd_id = '0;
  // result side
  logic               res_valid;
  logic               res_stall = 1'b0;
  logic [ValW-1:0]    res_id;
  logic [IdxW-1:0]    res_index;
  logic [1:0]         res_status;
  logic [LenOutW-1:0] res_length;
  logic               res_last;

  int failures;
  int expected_left;
  int predicted_len;
  int sent = 0;
  int cycles = 0;
  bit quiet = 1'b0;   // no idling on either side while set
  int stall_left = 0;
  int run_left = 0;

  always #5 clk = ~clk;

  positional_list_engine #(.CAPACITY(CAPACITY)) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (cmd_valid),
    .in_stall_o   (cmd_stall),
    .cmd_i        (cmd_op),
    .position_i   (cmd_pos),
    .value_i      (cmd_id),
    .out_valid_o  (res_valid),
    .out_stall_i  (res_stall),
    .value_out_o  (res_id),
    .entry_index_o(res_index),
    .status_o     (res_status),
    .length_o     (res_length),
    .last_o       (res_last)
  );

  list_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (cmd_valid),
    .in_stall_i   (cmd_stall),
    .cmd_i        (cmd_op),
    .position_i   (cmd_pos),
    .value_i      (cmd_id),
    .out_valid_i  (res_valid),
    .out_stall_i  (res_stall),
    .value_out_i  (res_id),
    .entry_index_i(res_index),
    .status_i     (res_status),
    .length_i     (res_length),
    .last_i       (res_last),
    .fail_count_o (failures),
    .pending_o    (expected_left),
    .list_len_o   (predicted_len)
  );

  // idle length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // result side stall pattern: bursts of stall separated by open runs
  always @(posedge clk) begin
    if (quiet) begin
      res_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      res_stall <= 1'b1;
      stall_left--;
    end else begin
      res_stall <= 1'b0;
      if (run_left > 0) begin
        run_left--;
      end else begin
        stall_left = pick_gap();
        run_left = $urandom_range(0, 8);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("[positional_list_engine] ERROR");
      $finish;
    end
  end

  // one command transaction: optional idle gap, then hold until taken
  task automatic send(logic [2:0] op, logic [PosW-1:0] pos, logic [ValW-1:0] id);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_op    <= op;
    cmd_pos   <= pos;
    cmd_id    <= id;
    do @(posedge clk); while (cmd_stall);
    sent++;
  endtask

  // sender holds off until the checker has nothing left in flight
  task automatic wait_drained();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
  endtask

  // position mostly inside the live range, sometimes at the ends, sometimes noise
  function automatic logic [PosW-1:0] pick_pos(bit for_insert);
    int top_pos;
    int r;
    top_pos = for_insert ? predicted_len : predicted_len - 1;
    r = $urandom_range(0, 99);
    if (r < 20 || top_pos < 0) return PosW'($urandom_range(0, 127));
    if (r < 30) return PosW'(top_pos);
    if (r < 35) return '0;
    return PosW'($urandom_range(0, top_pos));
  endfunction

  function automatic logic [ValW-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return IdOnes;
    if (r < 13) return '0;
    return ValW'($urandom);
  endfunction

  // random command with given insert and dump shares in percent
  task automatic send_random(int ins_pct, int dump_pct);
    int r;
    int k;
    logic [2:0] op;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 2);
    if (r < 2) op = CMD_UNUSED;
    else if (r < 2 + dump_pct) op = CMD_DUMP;
    else if (r < 2 + dump_pct + ins_pct)
      op = (k == 0) ? CMD_INS_HEAD : (k == 1) ? CMD_INS_TAIL : CMD_INS_POS;
    else
      op = (k == 0) ? CMD_REM_HEAD : (k == 1) ? CMD_REM_TAIL : CMD_REM_POS;
    send(op, pick_pos(op == CMD_INS_POS), pick_id());
  endtask

  initial begin
    int guard;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list corner cases
    send(CMD_REM_HEAD, 0, 0);
    send(CMD_REM_TAIL, 0, 0);
    send(CMD_REM_POS, 0, 0);      // bad position wins over empty
    send(CMD_DUMP, 0, 0);
    send(CMD_INS_POS, 1, 5);      // past the end
    send(CMD_UNUSED, 0, 0);
    // build a short list through every insert flavor
    send(CMD_INS_POS, 0, IdOnes);
    send(CMD_INS_HEAD, 0, '0);
    send(CMD_INS_TAIL, 0, 31'h2AAA_AAAA);
    send(CMD_INS_POS, 3, 31'h5555_5555);
    send(CMD_INS_POS, 2, 31'h1234_5678);
    send(CMD_INS_POS, 6, 1);
    send(CMD_INS_POS, 127, 1);
    send(CMD_DUMP, 0, 0);
    // removals: bad positions, middle, last entry, tail, head
    send(CMD_REM_POS, 5, 0);
    send(CMD_REM_POS, 127, 0);
    send(CMD_REM_POS, 2, 0);
    send(CMD_REM_POS, 3, 0);
    send(CMD_REM_TAIL, 0, 0);
    send(CMD_REM_HEAD, 0, 0);
    send(CMD_DUMP, 0, 0);
    send(CMD_UNUSED, 127, IdOnes);

    // grow the list to capacity
    guard = 0;
    while (predicted_len < CAPACITY && guard < 250) begin
      send_random(85, 4);
      guard++;
    end
    // hold off until every result is in, so the length seen here is exact
    wait_drained();
    while (predicted_len < CAPACITY) send(CMD_INS_TAIL, 0, pick_id());
    // full list: every insert flavor is refused, then a complete dump
    send(CMD_INS_HEAD, 0, pick_id());
    send(CMD_INS_TAIL, 0, pick_id());
    send(CMD_INS_POS, PosW'(CAPACITY), pick_id());
    send(CMD_INS_POS, 0, pick_id());
    send(CMD_DUMP, 0, 0);
    send(CMD_REM_POS, PosW'(CAPACITY - 1), 0);
    send(CMD_INS_POS, PosW'(CAPACITY - 1), pick_id());

    // balanced traffic around the upper end
    repeat (120) send_random(50, 6);

    // shrink to empty and poke at the empty list
    guard = 0;
    while (predicted_len > 0 && guard < 250) begin
      send_random(15, 4);
      guard++;
    end
    repeat (10) send_random(30, 10);

    // back to back on both sides
    quiet = 1'b1;
    repeat (80) send_random(55, 6);
    quiet = 1'b0;

    while (sent < ItemTarget) send_random(55, 7);

    wait_drained();
    repeat (200) @(posedge clk);
    if (failures == 0 && expected_left == 0) begin
      $display("[positional_list_engine] OK");
    end else begin
      $display("[positional_list_engine] ERROR");
    end
    $finish;
  end

endmodule
